### rtl/mcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcb_pkg
// Shared widths, codes and defaults of the message coalescing buffer.
// ----------------------------------------------------------------------------
package mcb_pkg;

  // field widths
  localparam int FUNC_W    = 1;
  localparam int HANDLER_W = 3;
  localparam int TARGET_W  = 4;
  localparam int RW_W      = 2;
  localparam int WORD_W    = 64;
  localparam int COUNT_W   = 6;
  localparam int NRES_W    = 7;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int LIMIT_W    = 6;
  localparam int PLACES_W   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_AGG_LIMIT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PLACES_IN_USE = 1'b1;

  localparam logic [LIMIT_W-1:0]  AGG_LIMIT_RST     = 6'd32;
  localparam logic [PLACES_W-1:0] PLACES_IN_USE_RST = 5'd16;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND    = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH_ALL = 1'b1;

  localparam logic [COUNT_W-1:0] TOTAL_MAX = 6'd63;
  localparam logic [NRES_W-1:0]  MAX_RESULTS = 7'd64;

  // default sizes
  localparam int HANDLERS_DEF  = 8;
  localparam int PLACES_DEF    = 16;
  localparam int BUF_WORDS_DEF = 32;

endpackage
`default_nettype wire

### rtl/mcb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcb_in_if
// Command channel: append a record or flush all buffers of a handler.
// ----------------------------------------------------------------------------
interface mcb_in_if;
  import mcb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [HANDLER_W-1:0] handler;
  logic [TARGET_W-1:0]  target;
  logic [RW_W-1:0]      record_words;
  logic [WORD_W-1:0]    arg_first;
  logic [WORD_W-1:0]    arg_second;

  modport source (output valid, func, handler, target, record_words, arg_first,
                  arg_second, input ready);
  modport sink (input valid, func, handler, target, record_words, arg_first,
                arg_second, output ready);
endinterface
`default_nettype wire

### rtl/mcb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcb_out_if
// Message word channel: one buffered word per transfer with its header.
// ----------------------------------------------------------------------------
interface mcb_out_if;
  import mcb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TARGET_W-1:0]  dest;
  logic [HANDLER_W-1:0] msg_handler;
  logic [COUNT_W-1:0]   record_count;
  logic [WORD_W-1:0]    payload_word;
  logic                 end_of_message;
  logic                 last;

  modport source (output valid, dest, msg_handler, record_count, payload_word,
                  end_of_message, last, input ready);
  modport sink (input valid, dest, msg_handler, record_count, payload_word,
                end_of_message, last, output ready);
endinterface
`default_nettype wire

### rtl/mcb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mcb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/message_coalescing_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// An append stores its record and, when the handler total nears the limit,
// scans the counts and sends the largest buffer; a flush-all scans the
// counts, then checks each destination in use and sends every nonempty
// buffer. One command is taken at a time; the count RAM scan and the single
// payload RAM read port bound the rate, and the scan covers the places in use.
// Reset: a clearing pass zeroes the count RAM;
// no command is taken until it ends. Payload RAM is not cleared.
// ----------------------------------------------------------------------------
// message_coalescing_buffer
// Per handler and destination record buffer; an append flushes the largest buffer.
// ----------------------------------------------------------------------------
module message_coalescing_buffer #(
  parameter int HANDLERS  = mcb_pkg::HANDLERS_DEF,
  parameter int PLACES    = mcb_pkg::PLACES_DEF,
  parameter int BUF_WORDS = mcb_pkg::BUF_WORDS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  mcb_in_if.sink                               in_if,
  mcb_out_if.source                            out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [mcb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mcb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import mcb_pkg::*;

  localparam int SLOTS  = HANDLERS * PLACES;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WORDS  = SLOTS * BUF_WORDS;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int DW     = (PLACES > 1) ? $clog2(PLACES) : 1;
  localparam int PW     = $clog2(PLACES + 1);
  localparam int HW     = (HANDLERS > 1) ? $clog2(HANDLERS) : 1;
  localparam int LW     = $clog2(BUF_WORDS + 1);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_AP_CNT = 10'b00_0000_0100,
    S_AP_W2  = 10'b00_0000_1000,
    S_SCAN   = 10'b00_0001_0000,
    S_FA_RD  = 10'b00_0010_0000,
    S_FA_CNT = 10'b00_0100_0000,
    S_SD_RD  = 10'b00_1000_0000,
    S_SD_OUT = 10'b01_0000_0000,
    S_SPARE  = 10'b10_0000_0000
  } state_e;

  function automatic logic [SLOT_W-1:0] slot_of(logic [HW-1:0] h, logic [DW-1:0] d);
    slot_of = SLOT_W'(32'(h) * PLACES + 32'(d));
  endfunction

  // configuration
  logic [LIMIT_W-1:0]  agg_q;
  logic [PLACES_W-1:0] plc_q;
  logic [LW-1:0]       lim_eff;
  logic [PW-1:0]       plc_eff;

  always_comb begin
    if (agg_q < 6'd2) lim_eff = LW'(2);
    else if (32'(agg_q) > BUF_WORDS) lim_eff = LW'(BUF_WORDS);
    else lim_eff = LW'(agg_q);
    if (plc_q == 5'd0) plc_eff = PW'(1);
    else if (32'(plc_q) > PLACES) plc_eff = PW'(PLACES);
    else plc_eff = PW'(plc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agg_q <= AGG_LIMIT_RST;
      plc_q <= PLACES_IN_USE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AGG_LIMIT:     agg_q <= cfg_wdata_i[LIMIT_W-1:0];
        REG_PLACES_IN_USE: plc_q <= cfg_wdata_i[PLACES_W-1:0];
        default: ;
      endcase
    end
  end

  // memories
  logic                cm_we;
  logic [SLOT_W-1:0]   cm_waddr, cm_raddr;
  logic [COUNT_W-1:0]  cm_wdata, cm_rdata;
  logic                pm_we;
  logic [ADDR_W-1:0]   pm_waddr, pm_raddr;
  logic [WORD_W-1:0]   pm_wdata, pm_rdata;

  mcb_ram #(.WIDTH(COUNT_W), .DEPTH(SLOTS), .AW(SLOT_W)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (cm_waddr),
    .wdata_i (cm_wdata),
    .raddr_i (cm_raddr),
    .rdata_o (cm_rdata)
  );

  mcb_ram #(.WIDTH(WORD_W), .DEPTH(WORDS), .AW(ADDR_W)) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  // control state
  state_e             state_q, state_d;
  logic [SLOT_W-1:0]  clr_q, clr_d;
  logic [PW-1:0]      scan_rd_q, scan_rd_d;
  logic               pend_q, pend_d;
  logic [DW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [COUNT_W-1:0] best_cnt_q, best_cnt_d;
  logic [DW-1:0]      best_d_q, best_d_d;
  logic [DW-1:0]      lastnz_q, lastnz_d;
  logic               anynz_q, anynz_d;
  logic               flush_q, flush_d;
  logic [DW-1:0]      sd_d_q, sd_d_d;
  logic [COUNT_W-1:0] sd_cnt_q, sd_cnt_d;
  logic [LW-1:0]      words_q, words_d;
  logic [LW-1:0]      w_q, w_d;
  logic [NRES_W-1:0]  n_q, n_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [COUNT_W-1:0] tot_q [HANDLERS];
  logic               tot_we;
  logic [COUNT_W-1:0] tot_wdata;

  // latched command
  logic [FUNC_W-1:0]  func_q;
  logic [HW-1:0]      hidx_q;
  logic [HANDLER_W-1:0] h_q;
  logic [TARGET_W-1:0] t_q;
  logic [RW_W-1:0]    rw_q;
  logic [WORD_W-1:0]  arg1_q, arg2_q;
  logic [LW-1:0]      lim_q;
  logic [PW-1:0]      peff_q;

  // output register
  logic                 ov_q;
  logic                 out_ld;
  logic [TARGET_W-1:0]  o_dest_q;
  logic [HANDLER_W-1:0] o_hdl_q;
  logic [COUNT_W-1:0]   o_cnt_q;
  logic [WORD_W-1:0]    o_word_q;
  logic                 o_eom_q, o_last_q;
  logic                 eom_word, o_eom, o_last;

  logic               in_acc;
  logic               cmd_ok, tgt_ok;
  logic [COUNT_W-1:0] tot_cur;
  logic               full, flush_now;
  logic [ADDR_W-1:0]  base_now;
  logic               st_go;
  logic [DW-1:0]      st_d;
  logic [COUNT_W-1:0] st_cnt;
  logic [31:0]        st_words;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign tot_cur     = tot_q[hidx_q];

  assign cmd_ok = (in_if.record_words == 2'd1 || in_if.record_words == 2'd2) &&
                  (32'(in_if.handler) < HANDLERS);
  assign tgt_ok = 32'(in_if.target) < 32'(plc_eff);

  assign full      = ((32'(cm_rdata) + 1) * 32'(rw_q) > 32'(lim_q)) || (tot_cur >= TOTAL_MAX);
  assign flush_now = (32'(tot_cur) + 2) * 32'(rw_q) >= 32'(lim_q);
  assign base_now  = ADDR_W'(32'(slot_of(hidx_q, DW'(t_q))) * BUF_WORDS +
                             32'(cm_rdata) * 32'(rw_q));
  assign st_words  = 32'(st_cnt) * 32'(rw_q);

  assign pm_raddr = ADDR_W'(32'(slot_of(hidx_q, sd_d_q)) * BUF_WORDS + 32'(w_q));

  assign eom_word = (32'(w_q) + 1 == 32'(words_q));
  assign o_eom    = eom_word || (n_q == MAX_RESULTS - 7'd1);
  assign o_last   = (n_q == MAX_RESULTS - 7'd1) ||
                    (eom_word && (func_q == FUNC_APPEND || sd_d_q == lastnz_q));

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    scan_rd_d  = scan_rd_q;
    pend_d     = pend_q;
    cmp_idx_d  = cmp_idx_q;
    best_cnt_d = best_cnt_q;
    best_d_d   = best_d_q;
    lastnz_d   = lastnz_q;
    anynz_d    = anynz_q;
    flush_d    = flush_q;
    sd_d_d     = sd_d_q;
    sd_cnt_d   = sd_cnt_q;
    words_d    = words_q;
    w_d        = w_q;
    n_d        = n_q;
    base_d     = base_q;
    cm_we      = 1'b0;
    cm_waddr   = clr_q;
    cm_wdata   = '0;
    cm_raddr   = slot_of(hidx_q, DW'(scan_rd_q));
    pm_we      = 1'b0;
    pm_waddr   = base_q;
    pm_wdata   = arg2_q;
    tot_we     = 1'b0;
    tot_wdata  = tot_cur;
    out_ld     = 1'b0;
    st_go      = 1'b0;
    st_d       = cmp_idx_q;
    st_cnt     = cm_rdata;

    unique case (state_q)
      S_CLEAR: begin
        cm_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == SLOT_W'(SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        cm_raddr = slot_of(HW'(in_if.handler), DW'(in_if.target));
        if (in_acc) begin
          n_d        = '0;
          scan_rd_d  = '0;
          pend_d     = 1'b0;
          best_cnt_d = '0;
          best_d_d   = '0;
          lastnz_d   = '0;
          anynz_d    = 1'b0;
          if (cmd_ok) begin
            if (in_if.func == FUNC_FLUSH_ALL) state_d = S_SCAN;
            else if (tgt_ok) state_d = S_AP_CNT;
          end
        end
      end
      S_AP_CNT: begin
        if (full) begin
          state_d = S_IDLE;
        end else begin
          pm_we     = 1'b1;
          pm_waddr  = base_now;
          pm_wdata  = arg1_q;
          base_d    = base_now + 1'b1;
          cm_we     = 1'b1;
          cm_waddr  = slot_of(hidx_q, DW'(t_q));
          cm_wdata  = cm_rdata + 1'b1;
          tot_we    = 1'b1;
          tot_wdata = tot_cur + 1'b1;
          flush_d   = flush_now;
          if (rw_q == 2'd2) state_d = S_AP_W2;
          else state_d = flush_now ? S_SCAN : S_IDLE;
        end
      end
      S_AP_W2: begin
        pm_we   = 1'b1;
        state_d = flush_q ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        // one count read issued per cycle, compared in the next cycle
        if (32'(scan_rd_q) < 32'(peff_q)) begin
          scan_rd_d = scan_rd_q + 1'b1;
          pend_d    = 1'b1;
          cmp_idx_d = DW'(scan_rd_q);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (cm_rdata > best_cnt_q) begin
            best_cnt_d = cm_rdata;
            best_d_d   = cmp_idx_q;
          end
          if (cm_rdata != '0) begin
            lastnz_d = cmp_idx_q;
            anynz_d  = 1'b1;
          end
        end else if (scan_rd_q == peff_q) begin
          if (func_q == FUNC_APPEND) begin
            if (best_cnt_q != '0) begin
              st_go  = 1'b1;
              st_d   = best_d_q;
              st_cnt = best_cnt_q;
            end else begin
              state_d = S_IDLE;
            end
          end else if (anynz_q) begin
            scan_rd_d = '0;
            state_d   = S_FA_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FA_RD: begin
        if (32'(scan_rd_q) < 32'(peff_q)) begin
          cmp_idx_d = DW'(scan_rd_q);
          scan_rd_d = scan_rd_q + 1'b1;
          state_d   = S_FA_CNT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FA_CNT: begin
        if (cm_rdata != '0) st_go = 1'b1;
        else state_d = S_FA_RD;
      end
      S_SD_RD: begin
        // past the result cap the buffer is only cleared
        if (n_q == MAX_RESULTS) state_d = (func_q == FUNC_APPEND) ? S_IDLE : S_FA_RD;
        else state_d = S_SD_OUT;
      end
      S_SD_OUT: begin
        if (!ov_q || out_if.ready) begin
          out_ld = 1'b1;
          n_d    = n_q + 1'b1;
          w_d    = w_q + 1'b1;
          if (eom_word) state_d = (func_q == FUNC_APPEND) ? S_IDLE : S_FA_RD;
          else state_d = S_SD_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (st_go) begin
      cm_we     = 1'b1;
      cm_waddr  = slot_of(hidx_q, st_d);
      cm_wdata  = '0;
      tot_we    = 1'b1;
      tot_wdata = (tot_cur >= st_cnt) ? tot_cur - st_cnt : '0;
      sd_d_d    = st_d;
      sd_cnt_d  = st_cnt;
      words_d   = (st_words > BUF_WORDS) ? LW'(BUF_WORDS) : LW'(st_words);
      w_d       = '0;
      state_d   = S_SD_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      scan_rd_q  <= '0;
      pend_q     <= 1'b0;
      cmp_idx_q  <= '0;
      best_cnt_q <= '0;
      best_d_q   <= '0;
      lastnz_q   <= '0;
      anynz_q    <= 1'b0;
      flush_q    <= 1'b0;
      sd_d_q     <= '0;
      sd_cnt_q   <= '0;
      words_q    <= '0;
      w_q        <= '0;
      n_q        <= '0;
      base_q     <= '0;
      ov_q       <= 1'b0;
      for (int i = 0; i < HANDLERS; i++) tot_q[i] <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      scan_rd_q  <= scan_rd_d;
      pend_q     <= pend_d;
      cmp_idx_q  <= cmp_idx_d;
      best_cnt_q <= best_cnt_d;
      best_d_q   <= best_d_d;
      lastnz_q   <= lastnz_d;
      anynz_q    <= anynz_d;
      flush_q    <= flush_d;
      sd_d_q     <= sd_d_d;
      sd_cnt_q   <= sd_cnt_d;
      words_q    <= words_d;
      w_q        <= w_d;
      n_q        <= n_d;
      base_q     <= base_d;
      if (tot_we) tot_q[hidx_q] <= tot_wdata;
      if (out_ld) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= in_if.func;
      hidx_q <= HW'(in_if.handler);
      h_q    <= in_if.handler;
      t_q    <= in_if.target;
      rw_q   <= in_if.record_words;
      arg1_q <= in_if.arg_first;
      arg2_q <= in_if.arg_second;
      lim_q  <= lim_eff;
      peff_q <= plc_eff;
    end
    if (out_ld) begin
      o_dest_q <= TARGET_W'(sd_d_q);
      o_hdl_q  <= h_q;
      o_cnt_q  <= sd_cnt_q;
      o_word_q <= pm_rdata;
      o_eom_q  <= o_eom;
      o_last_q <= o_last;
    end
  end

  assign out_if.valid          = ov_q;
  assign out_if.dest           = o_dest_q;
  assign out_if.msg_handler    = o_hdl_q;
  assign out_if.record_count   = o_cnt_q;
  assign out_if.payload_word   = o_word_q;
  assign out_if.end_of_message = o_eom_q;
  assign out_if.last           = o_last_q;

`ifndef SYNTH
  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= MAX_RESULTS)
    else $error("more results than the cap for one command");

  a_no_cmd_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_if.ready)
    else $error("command taken during count clearing");

  a_payload_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pm_we |-> (state_q == S_AP_CNT || state_q == S_AP_W2))
    else $error("payload write outside an append");

  a_load_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |=> out_if.valid)
    else $error("loaded word not presented");
`endif

endmodule
`default_nettype wire

### sim/mcb_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcb_scoreboard
// Watches the command, message and configuration ports of the coalescing
// buffer, predicts every message word, and checks each word field by field.
// ----------------------------------------------------------------------------
module mcb_scoreboard
  import mcb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mcb_in_if                          in_m,
  mcb_out_if                         out_m,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                         pending_o,
  output int                         errors_o
);

  localparam int NH = HANDLERS_DEF;
  localparam int NP = PLACES_DEF;
  localparam int NW = BUF_WORDS_DEF;

  typedef struct packed {
    logic [TARGET_W-1:0]  dest;
    logic [HANDLER_W-1:0] hdl;
    logic [COUNT_W-1:0]   cnt;
    logic [WORD_W-1:0]    word;
    logic                 eom;
    logic                 last;
  } msg_word_t;

  logic [COUNT_W-1:0]  dest_cnt  [NH][NP];
  logic [COUNT_W-1:0]  hdl_total [NH];
  logic [WORD_W-1:0]   word_mem  [NH][NP][NW];
  logic [LIMIT_W-1:0]  limit_reg;
  logic [PLACES_W-1:0] places_reg;

  msg_word_t msg_q[$];
  msg_word_t burst_q[$];
  int        err_cnt;

  // stream one destination buffer into the burst, then clear its count
  function automatic void send_dest(int h, int d, int rw);
    int cnt;
    int words;
    msg_word_t m;
    cnt   = int'(dest_cnt[h][d]);
    words = cnt * rw;
    if (words > NW) words = NW;
    for (int w = 0; w < words; w++) begin
      if (burst_q.size() < int'(MAX_RESULTS)) begin
        m.dest = TARGET_W'(d);
        m.hdl  = HANDLER_W'(h);
        m.cnt  = COUNT_W'(cnt);
        m.word = word_mem[h][d][w];
        m.eom  = (w + 1 == words) || (burst_q.size() + 1 == int'(MAX_RESULTS));
        m.last = 1'b0;
        burst_q.push_back(m);
      end
    end
    if (int'(hdl_total[h]) >= cnt) hdl_total[h] = COUNT_W'(int'(hdl_total[h]) - cnt);
    else hdl_total[h] = '0;
    dest_cnt[h][d] = '0;
  endfunction

  function automatic void predict_command(logic [FUNC_W-1:0] fn, int h, int t, int rw,
                                          logic [WORD_W-1:0] a0, logic [WORD_W-1:0] a1);
    int lim;
    int pl;
    int cnt;
    int total;
    int best;
    int bestd;
    lim = int'(limit_reg);
    if (lim < 2) lim = 2;
    if (lim > NW) lim = NW;
    pl = int'(places_reg);
    if (pl < 1) pl = 1;
    if (pl > NP) pl = NP;
    burst_q.delete();
    if (rw < 1 || rw > 2 || h >= NH) return;
    if (fn == FUNC_FLUSH_ALL) begin
      for (int d = 0; d < pl; d++)
        if (dest_cnt[h][d] != 0) send_dest(h, d, rw);
    end else begin
      if (t >= pl) return;
      cnt = int'(dest_cnt[h][t]);
      if ((cnt + 1) * rw > lim || hdl_total[h] >= TOTAL_MAX) return;
      word_mem[h][t][cnt * rw] = a0;
      if (rw == 2) word_mem[h][t][cnt * rw + 1] = a1;
      dest_cnt[h][t] = COUNT_W'(cnt + 1);
      hdl_total[h]   = COUNT_W'(int'(hdl_total[h]) + 1);
      total = int'(hdl_total[h]);
      if ((total + 1) * rw >= lim || total + 1 >= lim) begin
        best  = 0;
        bestd = 0;
        for (int d = 0; d < pl; d++)
          if (int'(dest_cnt[h][d]) > best) begin
            best  = int'(dest_cnt[h][d]);
            bestd = d;
          end
        if (best > 0) send_dest(h, bestd, rw);
      end
    end
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
    foreach (burst_q[i]) msg_q.push_back(burst_q[i]);
  endfunction

  function automatic void check_word();
    msg_word_t e;
    if (msg_q.size() == 0) begin
      $error("unexpected message word: dest %0d handler %0d word %h",
             out_m.dest, out_m.msg_handler, out_m.payload_word);
      err_cnt++;
      return;
    end
    e = msg_q.pop_front();
    if (out_m.dest !== e.dest) begin
      $error("dest: expected %0d actual %0d", e.dest, out_m.dest);
      err_cnt++;
    end
    if (out_m.msg_handler !== e.hdl) begin
      $error("msg_handler: expected %0d actual %0d", e.hdl, out_m.msg_handler);
      err_cnt++;
    end
    if (out_m.record_count !== e.cnt) begin
      $error("record_count: expected %0d actual %0d", e.cnt, out_m.record_count);
      err_cnt++;
    end
    if (out_m.payload_word !== e.word) begin
      $error("payload_word: expected %h actual %h", e.word, out_m.payload_word);
      err_cnt++;
    end
    if (out_m.end_of_message !== e.eom) begin
      $error("end_of_message: expected %0b actual %0b", e.eom, out_m.end_of_message);
      err_cnt++;
    end
    if (out_m.last !== e.last) begin
      $error("last: expected %0b actual %0b", e.last, out_m.last);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (dest_cnt[h, d]) dest_cnt[h][d] = '0;
      foreach (hdl_total[h]) hdl_total[h] = '0;
      limit_reg  = AGG_LIMIT_RST;
      places_reg = PLACES_IN_USE_RST;
      msg_q.delete();
      err_cnt   = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_AGG_LIMIT) limit_reg = cfg_wdata_i[LIMIT_W-1:0];
        else if (cfg_idx_i == REG_PLACES_IN_USE) places_reg = cfg_wdata_i[PLACES_W-1:0];
      end
      // compare first: words of a command taken at this edge come out later
      if (out_m.valid && out_m.ready) check_word();
      if (in_m.valid && in_m.ready)
        predict_command(in_m.func, int'(in_m.handler), int'(in_m.target),
                        int'(in_m.record_words), in_m.arg_first, in_m.arg_second);
      pending_o <= msg_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

### sim/tb_message_coalescing_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_coalescing_buffer
// Drives directed and random append and flush-all commands through several
// limit and destination settings with bursty sending and a stalling receiver;
// the scoreboard beside the block checks every message word.
// ----------------------------------------------------------------------------
module tb_message_coalescing_buffer;
  import mcb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 80;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    pending;
  int                    errors;
  int                    cycles;
  int                    cur_places;
  logic                  hold_req;
  logic                  hold_done;

  mcb_in_if  in_ch ();
  mcb_out_if out_ch ();

  message_coalescing_buffer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  mcb_scoreboard chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_m        (in_ch),
    .out_m       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: stall pattern cycles through four modes, one long hold on request
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        mode = (cycles / 50) % 4;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // a handler keeps one record size, so its buffer never mixes sizes
  function automatic int size_of(int h);
    return (h < 4) ? 1 : 2;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic offer(logic [FUNC_W-1:0] fn, int h, int t, int rw,
                       logic [WORD_W-1:0] a0, logic [WORD_W-1:0] a1);
    in_ch.valid        <= 1'b1;
    in_ch.func         <= fn;
    in_ch.handler      <= HANDLER_W'(h);
    in_ch.target       <= TARGET_W'(t);
    in_ch.record_words <= RW_W'(rw);
    in_ch.arg_first    <= a0;
    in_ch.arg_second   <= a1;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(int lim, int pl);
    drain();
    write_reg(REG_AGG_LIMIT, lim);
    write_reg(REG_PLACES_IN_USE, pl);
    cur_places = (pl < 1) ? 1 : (pl > 16 ? 16 : pl);
  endtask

  task automatic rand_command(int hot);
    int r;
    int h;
    int t;
    r = $urandom_range(0, 99);
    h = ($urandom_range(0, 99) < 70) ? hot + 4 * $urandom_range(0, 1) : $urandom_range(0, 7);
    t = $urandom_range(0, cur_places - 1);
    if (r < 8)
      offer(FUNC_APPEND, h, $urandom_range(0, 15), 3 * $urandom_range(0, 1),
            rand_word(), rand_word());
    else if (r < 12)
      offer(FUNC_FLUSH_ALL, h, t, 3 * $urandom_range(0, 1), rand_word(), rand_word());
    else if (r < 18 && cur_places < 16)
      offer(FUNC_APPEND, h, $urandom_range(cur_places, 15), size_of(h),
            rand_word(), rand_word());
    else if (r < 26)
      offer(FUNC_FLUSH_ALL, h, $urandom_range(0, 15), size_of(h), rand_word(), rand_word());
    else
      offer(FUNC_APPEND, h, t, size_of(h), rand_word(), rand_word());
  endtask

  initial begin
    int lims  [5] = '{63, 0, 9, 1, 32};
    int plcs  [5] = '{31, 0, 5, 16, 16};
    int burst;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_AGG_LIMIT;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_APPEND;
    in_ch.handler      = '0;
    in_ch.target       = '0;
    in_ch.record_words = '0;
    in_ch.arg_first    = '0;
    in_ch.arg_second   = '0;
    hold_req           = 1'b0;
    cur_places         = 16;
    rst_ni             = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, extremes of the words and targets
    offer(FUNC_APPEND, 0, 0, 1, '1, '0);
    offer(FUNC_APPEND, 0, 15, 1, '0, '1);
    offer(FUNC_APPEND, 7, 0, 2, '1, '0);
    offer(FUNC_APPEND, 7, 15, 2, '0, '1);
    offer(FUNC_APPEND, 1, 2, 0, '1, '1);
    offer(FUNC_FLUSH_ALL, 0, 0, 3, '0, '0);
    offer(FUNC_FLUSH_ALL, 0, 0, 1, '0, '0);
    offer(FUNC_FLUSH_ALL, 7, 0, 2, '0, '0);
    offer(FUNC_FLUSH_ALL, 2, 0, 1, '0, '0);
    drop_valid();

    // directed: small limit, three destinations, ties and out-of-range target
    set_mode(4, 3);
    offer(FUNC_APPEND, 5, 1, 2, rand_word(), rand_word());
    offer(FUNC_APPEND, 1, 0, 1, rand_word(), '0);
    offer(FUNC_APPEND, 1, 1, 1, rand_word(), '0);
    offer(FUNC_APPEND, 1, 9, 1, rand_word(), '0);
    offer(FUNC_APPEND, 1, 1, 1, rand_word(), '0);
    offer(FUNC_APPEND, 2, 0, 1, rand_word(), '0);
    offer(FUNC_APPEND, 2, 2, 1, rand_word(), '0);
    offer(FUNC_APPEND, 2, 0, 1, rand_word(), '0);
    offer(FUNC_APPEND, 3, 2, 1, rand_word(), '0);
    offer(FUNC_APPEND, 3, 2, 1, rand_word(), '0);
    offer(FUNC_FLUSH_ALL, 3, 0, 1, '0, '0);
    offer(FUNC_FLUSH_ALL, 1, 0, 1, '0, '0);
    drop_valid();

    for (int ph = 0; ph < 5; ph++) begin
      set_mode(lims[ph], plcs[ph]);
      for (int n = 0; n < 44; ) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && n < 44; b++, n++) begin
          if (ph == 2 && n == 10) hold_req = 1'b1;
          rand_command(ph % 4);
        end
        if ($urandom_range(0, 3) != 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      drop_valid();
    end

    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### message_coalescing_buffer.f
rtl/mcb_pkg.sv
rtl/mcb_in_if.sv
rtl/mcb_out_if.sv
rtl/mcb_ram.sv
rtl/message_coalescing_buffer.sv
sim/mcb_scoreboard.sv
sim/tb_message_coalescing_buffer.sv
